@@ hw/rtl/pbm_pkg.sv @@
// ----------------------------------------------------------------------------
// pbm_pkg
// Types and constants shared by the pixel background model modules.
// ----------------------------------------------------------------------------
package pbm_pkg;

  localparam int IDX_W   = 14;
  localparam int PIX_W   = 16;
  localparam int FUNC_W  = 3;
  localparam int STORE_W = 32;

  // Normalize dividend: a 32-bit sum, scaled by 256 for the mean, plus half the divisor.
  localparam int DVD_W = 41;
  localparam int CNT_W = $clog2(DVD_W);

  // sqrt(2) in 1.16 fixed point.
  localparam logic [16:0] SQRT2_Q16 = 17'd92682;

  localparam logic [FUNC_W-1:0] FUNC_SUM_MEAN    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUM_SPREAD  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_NORM_MEAN   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_NORM_SPREAD = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLASSIFY    = 3'd4;

  localparam logic [1:0] REG_ZETA    = 2'd0;
  localparam logic [1:0] REG_BG_RATE = 2'd1;
  localparam logic [1:0] REG_FG_RATE = 2'd2;

  localparam logic [15:0] ZETA_RESET    = 16'd2560;
  localparam logic [15:0] BG_RATE_RESET = 16'd655;
  localparam logic [15:0] FG_RATE_RESET = 16'd3277;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SUM_MEAN,
    OP_SUM_SPREAD,
    OP_NORM_MEAN,
    OP_NORM_SPREAD,
    OP_CLASSIFY
  } op_t;

  typedef struct packed {
    op_t  op;
    logic err;
  } phase_ctrl_t;

endpackage

@@ hw/rtl/pbm_regs.sv @@
// ----------------------------------------------------------------------------
// pbm_regs
// APB register file holding the band margin and the two learning rates.
// ----------------------------------------------------------------------------
module pbm_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] zeta,
  output logic [15:0] bg_rate,
  output logic [15:0] fg_rate
);
  import pbm_pkg::*;

  logic       wr;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      zeta    <= ZETA_RESET;
      bg_rate <= BG_RATE_RESET;
      fg_rate <= FG_RATE_RESET;
    end else if (wr) begin
      case (reg_sel)
        REG_ZETA:    zeta    <= pwdata[15:0];
        REG_BG_RATE: bg_rate <= pwdata[15:0];
        REG_FG_RATE: fg_rate <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ZETA:    prdata = {16'd0, zeta};
      REG_BG_RATE: prdata = {16'd0, bg_rate};
      REG_FG_RATE: prdata = {16'd0, fg_rate};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

@@ hw/rtl/pbm_phase.sv @@
// ----------------------------------------------------------------------------
// pbm_phase
// Frame counters and phase flags; decides at transfer time what an item does.
// ----------------------------------------------------------------------------
module pbm_phase #(
  parameter int PIXELS     = 16384,
  parameter int MAX_FRAMES = 256,
  parameter int NW         = 9
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [pbm_pkg::FUNC_W-1:0] func,
  input  logic [pbm_pkg::IDX_W-1:0]  idx,
  output pbm_pkg::phase_ctrl_t       ctrl,
  output logic [NW-1:0]              frames
);
  import pbm_pkg::*;

  logic [NW-1:0] mean_frames, mean_frames_next;
  logic [NW-1:0] spread_frames, spread_frames_next;
  logic          mean_ready, mean_ready_next;
  logic          spread_ready, spread_ready_next;
  logic          first, last, oob, mean_full, spread_full;

  assign first       = (idx == '0);
  assign last        = (32'(idx) == 32'(PIXELS - 1));
  assign oob         = (32'(idx) >= 32'(PIXELS));
  assign mean_full   = (mean_frames == NW'(MAX_FRAMES));
  assign spread_full = (spread_frames == NW'(MAX_FRAMES));
  assign frames      = (func == FUNC_NORM_MEAN) ? mean_frames : spread_frames;

  always_comb begin
    ctrl               = '{op: OP_NONE, err: 1'b1};
    mean_frames_next   = mean_frames;
    spread_frames_next = spread_frames;
    mean_ready_next    = mean_ready;
    spread_ready_next  = spread_ready;
    if (!oob) begin
      case (func)
        FUNC_SUM_MEAN: begin
          if (!mean_ready) begin
            ctrl = '{op: OP_SUM_MEAN, err: 1'b0};
            if (first) begin
              if (mean_full) ctrl.err = 1'b1;
              else mean_frames_next = mean_frames + 1'b1;
            end
          end
        end
        FUNC_SUM_SPREAD: begin
          if (mean_ready && !spread_ready) begin
            ctrl = '{op: OP_SUM_SPREAD, err: 1'b0};
            if (first) begin
              if (spread_full) ctrl.err = 1'b1;
              else spread_frames_next = spread_frames + 1'b1;
            end
          end
        end
        FUNC_NORM_MEAN: begin
          if (!mean_ready && mean_frames != '0) begin
            ctrl = '{op: OP_NORM_MEAN, err: 1'b0};
            if (last) mean_ready_next = 1'b1;
          end
        end
        FUNC_NORM_SPREAD: begin
          if (mean_ready && !spread_ready && spread_frames != '0) begin
            ctrl = '{op: OP_NORM_SPREAD, err: 1'b0};
            if (last) spread_ready_next = 1'b1;
          end
        end
        FUNC_CLASSIFY: begin
          if (spread_ready) ctrl = '{op: OP_CLASSIFY, err: 1'b0};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_frames   <= '0;
      spread_frames <= '0;
      mean_ready    <= 1'b0;
      spread_ready  <= 1'b0;
    end else if (accept) begin
      mean_frames   <= mean_frames_next;
      spread_frames <= spread_frames_next;
      mean_ready    <= mean_ready_next;
      spread_ready  <= spread_ready_next;
    end
  end

endmodule

@@ hw/rtl/pbm_div.sv @@
// ----------------------------------------------------------------------------
// pbm_div
// Restoring divider, one quotient bit per cycle, for the normalize passes.
// ----------------------------------------------------------------------------
module pbm_div #(
  parameter int NW = 9
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pbm_pkg::DVD_W-1:0] dividend,
  input  logic [NW-1:0]             divisor,
  output logic                      done,
  output logic [pbm_pkg::DVD_W-1:0] quotient
);
  import pbm_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    rem, dsr;
  logic [DVD_W-1:0] dvd;
  logic [NW:0]      rem_sh, rem_sub;
  logic             ge;

  assign rem_sh   = {rem, dvd[DVD_W-1]};
  assign ge       = (rem_sh >= {1'b0, dsr});
  assign rem_sub  = rem_sh - {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  // The dividend register shifts out from the top and collects quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CNT_W'(DVD_W - 1);
      rem <= '0;
      dsr <= divisor;
      dvd <= dividend;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      rem <= ge ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
      dvd <= {dvd[DVD_W-2:0], ge};
    end
  end

endmodule

@@ hw/rtl/pixel_background_model.sv @@
// ----------------------------------------------------------------------------
// pixel_background_model
// Per-pixel running-average background model with mean and spread stores.
// ----------------------------------------------------------------------------
// Items arrive on the s_ stream: func in s_tuser, pixel index and 8.8 gray
// value in s_tdata. Each item yields one result on the m_ stream: the index
// echo in m_tdata and the foreground and order error flags in m_tuser.
// The three registers are to be written over APB only while the stream is
// idle; the block itself does not enforce this. Both per-pixel stores sit
// in single-port-write memories whose read data is registered at the
// transfer; a four-stage read-modify-write pipeline then writes the entry
// back. Summing and classify items stream at one per cycle while neither a
// stall downstream nor an index match holds the input. A normalize item
// holds the second stage while the serial divider runs. An item whose pixel
// index matches one still in the pipeline waits until that earlier item
// has written back. After reset the block sweeps both memories to zero,
// one entry per cycle, over all PIXELS entries; s_tready stays low meanwhile.
// When m_tready is low the result holds in the output register and the
// pipeline keeps filling behind it until all stages are occupied.
// ----------------------------------------------------------------------------
module pixel_background_model #(
  parameter int PIXELS     = 16384,
  parameter int MAX_FRAMES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pixel_index[13:0], pixel_value[29:14]
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // index_out[13:0]
  output logic [1:0]  m_tuser,   // foreground[0], order_error[1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pbm_pkg::*;

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int NW = $clog2(MAX_FRAMES + 1);

  logic [15:0] zeta, bg_rate, fg_rate;

  logic [IDX_W-1:0] s_idx;
  logic [PIX_W-1:0] s_px;
  logic             accept;
  phase_ctrl_t      ctrl;
  logic [NW-1:0]    frames;

  logic [STORE_W-1:0] mean_mem [PIXELS];
  logic [STORE_W-1:0] spread_mem [PIXELS];
  logic [STORE_W-1:0] mean_rd, spread_rd;
  logic               mean_we, spread_we;
  logic [AW-1:0]      waddr;
  logic [STORE_W-1:0] mean_wd, spread_wd;

  logic          clr_active;
  logic [AW-1:0] clr_addr;

  // Stage A: read data available.
  logic             a_v, a_err;
  op_t              a_op;
  logic [IDX_W-1:0] a_idx;
  logic [PIX_W-1:0] a_px;
  logic [NW-1:0]    a_n;
  // Stage B: divider and amplitude multiplier.
  logic               b_v, b_err, b_fg;
  op_t                b_op;
  logic [IDX_W-1:0]   b_idx;
  logic [31:0]        b_d;
  logic signed [49:0] b_pm;
  logic [STORE_W-1:0] b_mean_rd, b_mean_sum, b_spread_rd;
  // Stage C: spread blend multiplier.
  logic               c_v, c_err, c_fg;
  op_t                c_op;
  logic [IDX_W-1:0]   c_idx;
  logic [32:0]        c_amp;
  logic [STORE_W-1:0] c_mean_w, c_spread_rd, c_div;
  // Stage D: write back.
  logic               d_v, d_err, d_fg;
  op_t                d_op;
  logic [IDX_W-1:0]   d_idx;
  logic signed [50:0] d_ps;
  logic [STORE_W-1:0] d_mean_w, d_spread_rd, d_spread_alt;

  logic out_free, d_take, c_take, b_take, a_take, b_go, hazard;

  logic               div_start, div_done;
  logic [DVD_W-1:0]   div_dvd, div_q;

  logic [32:0]        a_diff, a_half, a_msum;
  logic [31:0]        a_d;
  logic signed [49:0] a_pm;
  logic [49:0]        b_amp_p;
  logic signed [49:0] b_t;
  logic [STORE_W-1:0] b_blend, b_div;
  logic [33:0]        c_ssum, c_ds;
  logic [15:0]        c_rate;
  logic [STORE_W-1:0] c_ssat;
  logic signed [50:0] c_ps, d_t;
  logic [STORE_W-1:0] d_blend;

  pbm_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .zeta, .bg_rate, .fg_rate
  );

  assign s_idx  = s_tdata[13:0];
  assign s_px   = s_tdata[29:14];
  assign accept = s_tvalid & s_tready;

  pbm_phase #(.PIXELS(PIXELS), .MAX_FRAMES(MAX_FRAMES), .NW(NW)) u_phase (
    .clk, .rst, .accept, .func(s_tuser), .idx(s_idx), .ctrl, .frames
  );

  // Stage advance: each stage takes a new item when it is empty or moving on.
  assign out_free = !m_tvalid | m_tready;
  assign d_take   = !d_v | out_free;
  assign c_take   = !c_v | d_take;
  assign b_go     = !(b_op == OP_NORM_MEAN || b_op == OP_NORM_SPREAD) | div_done;
  assign b_take   = !b_v | (b_go & c_take);
  assign a_take   = !a_v | b_take;

  assign hazard = (a_v && a_idx == s_idx) || (b_v && b_idx == s_idx) ||
                  (c_v && c_idx == s_idx) || (d_v && d_idx == s_idx);
  assign s_tready = !clr_active & a_take & !hazard;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(PIXELS - 1)) clr_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mean_rd   <= mean_mem[AW'(s_idx)];
      spread_rd <= spread_mem[AW'(s_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (mean_we) mean_mem[waddr] <= mean_wd;
  end

  always_ff @(posedge clk) begin
    if (spread_we) spread_mem[waddr] <= spread_wd;
  end

  // Stage A arithmetic.
  assign a_diff = {9'd0, a_px, 8'd0} - {1'b0, mean_rd};
  assign a_d    = a_diff[32] ? 32'(-a_diff) : a_diff[31:0];
  assign a_half = {1'b0, spread_rd} + {9'd0, zeta, 8'd0};
  assign a_pm   = $signed(a_diff) * $signed({1'b0, bg_rate});
  assign a_msum = {1'b0, mean_rd} + {17'd0, a_px};

  assign div_start = a_v & b_take & (a_op == OP_NORM_MEAN || a_op == OP_NORM_SPREAD);
  assign div_dvd   = (a_op == OP_NORM_MEAN) ?
                     ({1'b0, mean_rd, 8'd0} + DVD_W'(a_n >> 1)) :
                     ({9'd0, spread_rd} + DVD_W'(a_n >> 1));

  pbm_div #(.NW(NW)) u_div (
    .clk, .rst, .start(div_start), .dividend(div_dvd), .divisor(a_n),
    .done(div_done), .quotient(div_q)
  );

  // Stage B arithmetic.
  assign b_amp_p = {18'd0, b_d} * 50'(SQRT2_Q16) + 50'd32768;
  assign b_t     = b_pm + 50'sd32768;
  assign b_blend = b_mean_rd + 32'(b_t >>> 16);
  assign b_div   = (b_op == OP_NORM_MEAN) ?
                   ((div_q[DVD_W-1:24] != '0) ? 32'h00FF_FFFF : {8'd0, div_q[23:0]}) :
                   ((div_q[DVD_W-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0]);

  // Stage C arithmetic.
  assign c_ssum = {2'd0, c_spread_rd} + {1'b0, c_amp};
  assign c_ssat = (c_ssum[33:32] != 2'd0) ? 32'hFFFF_FFFF : c_ssum[31:0];
  assign c_ds   = {1'b0, c_amp} - {2'd0, c_spread_rd};
  assign c_rate = c_fg ? fg_rate : bg_rate;
  assign c_ps   = $signed(c_ds) * $signed({1'b0, c_rate});

  // Stage D arithmetic.
  assign d_t     = d_ps + 51'sd32768;
  assign d_blend = d_spread_rd + 32'(d_t >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v      <= 1'b0;
      b_v      <= 1'b0;
      c_v      <= 1'b0;
      d_v      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (a_take) a_v <= accept;
      if (b_take) b_v <= a_v;
      if (c_take) c_v <= b_v & b_go;
      if (d_take) d_v <= c_v;
      if (out_free) m_tvalid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      a_op  <= ctrl.op;
      a_err <= ctrl.err;
      a_idx <= s_idx;
      a_px  <= s_px;
      a_n   <= frames;
    end
    if (b_take) begin
      b_op        <= a_op;
      b_err       <= a_err;
      b_idx       <= a_idx;
      b_fg        <= ({1'b0, a_d} > a_half);
      b_d         <= a_d;
      b_pm        <= a_pm;
      b_mean_rd   <= mean_rd;
      b_spread_rd <= spread_rd;
      b_mean_sum  <= a_msum[32] ? 32'hFFFF_FFFF : a_msum[31:0];
    end
    if (c_take) begin
      c_op        <= b_op;
      c_err       <= b_err;
      c_idx       <= b_idx;
      c_fg        <= b_fg;
      c_amp       <= b_amp_p[48:16];
      c_spread_rd <= b_spread_rd;
      c_div       <= b_div;
      case (b_op)
        OP_SUM_MEAN:  c_mean_w <= b_mean_sum;
        OP_NORM_MEAN: c_mean_w <= b_div;
        default:      c_mean_w <= b_blend;
      endcase
    end
    if (d_take) begin
      d_op         <= c_op;
      d_err        <= c_err;
      d_idx        <= c_idx;
      d_fg         <= c_fg;
      d_ps         <= c_ps;
      d_mean_w     <= c_mean_w;
      d_spread_rd  <= c_spread_rd;
      d_spread_alt <= (c_op == OP_SUM_SPREAD) ? c_ssat : c_div;
    end
    if (out_free) begin
      m_tdata <= {2'd0, d_idx};
      m_tuser <= {d_err, d_fg & !d_err & (d_op == OP_CLASSIFY)};
    end
  end

  // Write port: clearing sweep after reset, otherwise the item leaving stage D.
  always_comb begin
    waddr     = clr_active ? clr_addr : AW'(d_idx);
    mean_wd   = clr_active ? '0 : d_mean_w;
    spread_wd = clr_active ? '0 : ((d_op == OP_CLASSIFY) ? d_blend : d_spread_alt);
    mean_we   = clr_active | (d_v & out_free &
                (d_op == OP_SUM_MEAN || d_op == OP_NORM_MEAN ||
                 (d_op == OP_CLASSIFY && !d_fg)));
    spread_we = clr_active | (d_v & out_free &
                (d_op == OP_SUM_SPREAD || d_op == OP_NORM_SPREAD ||
                 d_op == OP_CLASSIFY));
  end

endmodule

@@ hw/rtl/pbm_checker.sv @@
// ----------------------------------------------------------------------------
// pbm_assertions
// Port-level checks on the pixel background model, bound to the top level.
// ----------------------------------------------------------------------------
module pbm_assertions (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // The memory clearing sweep starts at reset, so no transfer is taken then.
  a_rst_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready during memory clearing");

  // A rejected item never reports foreground.
  a_fg_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("foreground flagged on an order error");

endmodule

bind pixel_background_model pbm_assertions u_pbm_assertions (.*);

@@ test/pbm_checker.sv @@
// ----------------------------------------------------------------------------
// pbm_checker
// Watches the pixel stream, the result stream and the APB port of the pixel
// background model. It keeps its own copy of both pixel stores, the frame
// counts and the registers, predicts one result per accepted pixel and
// compares every returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module pbm_checker
  import pbm_pkg::*;
#(
  parameter int PIXELS     = 16384,
  parameter int MAX_FRAMES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             fg;
    logic             err;
  } pixel_result_t;

  pixel_result_t result_q[$];

  logic [31:0] mean_mem [PIXELS];
  logic [31:0] spread_mem [PIXELS];
  int unsigned mean_cnt, spread_cnt;
  bit          mean_done, spread_done;
  logic [15:0] zeta_r, bg_rate_r, fg_rate_r;

  assign pending = result_q.size();

  initial begin
    fail_count = 0;
    for (int i = 0; i < PIXELS; i++) begin
      mean_mem[i] = '0;
      spread_mem[i] = '0;
    end
    mean_cnt = 0;
    spread_cnt = 0;
    mean_done = 0;
    spread_done = 0;
    zeta_r = ZETA_RESET;
    bg_rate_r = BG_RATE_RESET;
    fg_rate_r = FG_RATE_RESET;
  end

  function automatic longint unsigned amp_of(longint unsigned x16, longint unsigned m);
    longint unsigned d;
    d = (x16 >= m) ? x16 - m : m - x16;
    return (d * 92682 + 32768) >> 16;
  endfunction

  // Arithmetic shift of the signed product gives the floor the update needs.
  function automatic logic [31:0] moved(logic [31:0] acc, longint unsigned v,
                                        logic [15:0] rate);
    longint t;
    t = (longint'(v) - longint'({32'd0, acc})) * longint'({48'd0, rate}) + 32768;
    return 32'(longint'({32'd0, acc}) + (t >>> 16));
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] a, longint unsigned b);
    longint unsigned s;
    s = {32'd0, a} + b;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic predict_pixel(logic [2:0] f, logic [IDX_W-1:0] idx, logic [15:0] val);
    pixel_result_t r;
    longint unsigned x16, q, n, a;
    longint m, half, x;
    x16 = {40'd0, val, 8'd0};
    r.idx = idx;
    r.fg = 0;
    r.err = 0;
    case (f)
      FUNC_SUM_MEAN: begin
        if (mean_done) r.err = 1;
        else begin
          if (idx == 0) begin
            if (mean_cnt >= MAX_FRAMES) r.err = 1;
            else mean_cnt++;
          end
          mean_mem[idx] = sat_sum(mean_mem[idx], {48'd0, val});
        end
      end
      FUNC_SUM_SPREAD: begin
        if (!mean_done || spread_done) r.err = 1;
        else begin
          if (idx == 0) begin
            if (spread_cnt >= MAX_FRAMES) r.err = 1;
            else spread_cnt++;
          end
          spread_mem[idx] = sat_sum(spread_mem[idx], amp_of(x16, {32'd0, mean_mem[idx]}));
        end
      end
      FUNC_NORM_MEAN: begin
        n = mean_cnt;
        if (mean_done || n == 0) r.err = 1;
        else begin
          q = ({32'd0, mean_mem[idx]} * 256 + n / 2) / n;
          mean_mem[idx] = (q > 64'hFF_FFFF) ? 32'hFF_FFFF : q[31:0];
          if (idx == PIXELS - 1) mean_done = 1;
        end
      end
      FUNC_NORM_SPREAD: begin
        n = spread_cnt;
        if (!mean_done || spread_done || n == 0) r.err = 1;
        else begin
          q = ({32'd0, spread_mem[idx]} + n / 2) / n;
          spread_mem[idx] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
          if (idx == PIXELS - 1) spread_done = 1;
        end
      end
      FUNC_CLASSIFY: begin
        if (!spread_done) r.err = 1;
        else begin
          m = longint'({32'd0, mean_mem[idx]});
          half = longint'({32'd0, spread_mem[idx]}) + longint'({40'd0, zeta_r, 8'd0});
          x = longint'(x16);
          a = amp_of(x16, {32'd0, mean_mem[idx]});
          if (x >= m - half && x <= m + half) begin
            mean_mem[idx] = moved(mean_mem[idx], x16, bg_rate_r);
            spread_mem[idx] = moved(spread_mem[idx], a, bg_rate_r);
          end else begin
            r.fg = 1;
            spread_mem[idx] = moved(spread_mem[idx], a, fg_rate_r);
          end
        end
      end
      default: r.err = 1;
    endcase
    if (r.err) r.fg = 0;
    result_q.push_back(r);
  endtask

  always @(posedge clk) begin
    pixel_result_t e;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ZETA:    zeta_r = pwdata[15:0];
          REG_BG_RATE: bg_rate_r = pwdata[15:0];
          REG_FG_RATE: fg_rate_r = pwdata[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        predict_pixel(s_tuser, s_tdata[13:0], s_tdata[29:14]);
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result idx=%0d fg=%0b err=%0b", $time,
                   m_tdata[13:0], m_tuser[0], m_tuser[1]);
          fail_count++;
        end else begin
          e = result_q.pop_front();
          if (m_tdata[13:0] !== e.idx) begin
            $display("%0t: index_out expected %0d actual %0d", $time, e.idx, m_tdata[13:0]);
            fail_count++;
          end
          if (m_tuser[0] !== e.fg) begin
            $display("%0t: foreground idx=%0d expected %0b actual %0b", $time, e.idx,
                     e.fg, m_tuser[0]);
            fail_count++;
          end
          if (m_tuser[1] !== e.err) begin
            $display("%0t: order_error idx=%0d expected %0b actual %0b", $time, e.idx,
                     e.err, m_tuser[1]);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the pixel background model.
// Walks the block through summing, normalizing and classifying phases with
// random pixels, out-of-order calls, register changes between phases, random
// idling on both streams and a long result stall.
// ----------------------------------------------------------------------------
module tb;
  import pbm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIXELS = 16384;
  localparam logic [2:0] FUNC_BAD_FIRST = 3'd5;
  localparam logic [2:0] FUNC_BAD_LAST  = 3'd7;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // pixel_index[13:0], pixel_value[29:14]
  logic [2:0]  s_tuser = '0;   // func[2:0]
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;        // index_out[13:0]
  logic [1:0]  m_tuser;        // foreground[0], order_error[1]
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending;
  int send_idle = 25, recv_idle = 52;
  bit stall_req = 0, stall_seen = 0;
  int stall_left = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  pixel_background_model #(.PIXELS(PIXELS)) u_dut (.*);

  pbm_checker #(.PIXELS(PIXELS)) u_check (.*);

  // Result side: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else if (stall_left > 0) begin
      m_tready <= 0;
      stall_left <= stall_left - 1;
    end else if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= 300;
      m_tready <= 0;
    end else m_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  task automatic send_pixel(logic [2:0] f, logic [13:0] idx, logic [15:0] val);
    if ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= f;
    s_tdata <= {2'b00, val, idx};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] reg_sel, logic [15:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] z, logic [15:0] bg, logic [15:0] fg);
    apb_write(REG_ZETA, z);
    apb_write(REG_BG_RATE, bg);
    apb_write(REG_FG_RATE, fg);
  endtask

  // A small pool of pixels keeps the stores revisited; index 0 starts a frame.
  function automatic logic [13:0] pool_idx();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 14'd0;
    if (r == 2) return 14'(PIXELS - 1);
    return 14'($urandom_range(1, 15));
  endfunction

  function automatic logic [2:0] bad_func();
    return 3'($urandom_range(FUNC_BAD_FIRST, FUNC_BAD_LAST));
  endfunction

  task automatic classify_run(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_pixel(3'($urandom_range(0, 7)), pool_idx(), 16'($urandom));
      else send_pixel(FUNC_CLASSIFY, pool_idx(), 16'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    set_regs(16'd0, 16'hFFFF, 16'd0);

    // Calls made before any phase is ready, the unused func codes and the first mean sums.
    send_pixel(FUNC_NORM_MEAN, 14'd3, 16'h1234);
    send_pixel(FUNC_SUM_SPREAD, 14'd0, 16'hFFFF);
    send_pixel(FUNC_NORM_SPREAD, 14'(PIXELS - 1), 16'd0);
    send_pixel(FUNC_CLASSIFY, 14'd5, 16'h8000);
    send_pixel(3'd5, 14'd1, 16'h0001);
    send_pixel(3'd6, 14'd2, 16'hFFFF);
    send_pixel(3'd7, 14'd3, 16'h0000);
    send_pixel(FUNC_SUM_MEAN, 14'd0, 16'h0000);
    send_pixel(FUNC_SUM_MEAN, 14'd0, 16'hFFFF);
    send_pixel(FUNC_SUM_MEAN, 14'(PIXELS - 1), 16'hFFFF);
    send_pixel(FUNC_SUM_MEAN, 14'd1, 16'h5A5A);
    send_pixel(FUNC_SUM_MEAN, 14'd1, 16'hA5A5);

    // Mean summing; index 0 is frequent enough to saturate the frame count.
    for (int i = 0; i < 420; i++) begin
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) send_pixel(bad_func(), pool_idx(), 16'($urandom));
      else if (r == 1) send_pixel(3'($urandom_range(1, 4)), pool_idx(), 16'($urandom));
      else if (r < 13) send_pixel(FUNC_SUM_MEAN, 14'd0, 16'($urandom));
      else send_pixel(FUNC_SUM_MEAN, pool_idx(), 16'($urandom));
    end
    for (int i = 0; i < 16; i++) send_pixel(FUNC_NORM_MEAN, 14'(i), 16'($urandom));
    send_pixel(FUNC_NORM_MEAN, 14'(PIXELS - 1), 16'($urandom));
    send_pixel(FUNC_SUM_MEAN, 14'd4, 16'h4444);
    send_pixel(FUNC_NORM_MEAN, 14'd4, 16'h4444);
    send_pixel(FUNC_NORM_SPREAD, 14'd4, 16'h4444);
    drain();

    set_regs(16'd2560, 16'd655, 16'd3277);
    send_idle = 52;
    recv_idle = 25;
    for (int i = 0; i < 320; i++) begin
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) send_pixel(bad_func(), pool_idx(), 16'($urandom));
      else if (r == 1) send_pixel(FUNC_SUM_MEAN, pool_idx(), 16'($urandom));
      else if (r == 2) send_pixel(FUNC_CLASSIFY, pool_idx(), 16'($urandom));
      else if (r < 8) send_pixel(FUNC_SUM_SPREAD, 14'd0, 16'($urandom));
      else send_pixel(FUNC_SUM_SPREAD, pool_idx(), 16'($urandom));
    end
    for (int i = 0; i < 16; i++) send_pixel(FUNC_NORM_SPREAD, 14'(i), 16'($urandom));
    send_pixel(FUNC_NORM_SPREAD, 14'(PIXELS - 1), 16'($urandom));
    drain();

    set_regs(16'd1024, 16'd20000, 16'd40000);
    stall_req = !stall_req;
    classify_run(400);
    drain();

    set_regs(16'hFFFF, 16'd0, 16'd0);
    send_idle = 0;
    recv_idle = 0;
    classify_run(350);
    drain();

    set_regs(16'd0, 16'hFFFF, 16'hFFFF);
    classify_run(250);
    drain();

    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #6ms;
    $display("tb: errors");
    $finish;
  end

endmodule
